### design/stacked_dots_frame_generator_core_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the stacked dots frame generator
// Shorthand for clocked, reset-qualified concurrent checks.
// ----------------------------------------------------------------------------
`ifndef STACKED_DOTS_FRAME_GENERATOR_CORE_MACROS_SVH
`define STACKED_DOTS_FRAME_GENERATOR_CORE_MACROS_SVH

// same-cycle implication
`define SDFG_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define SDFG_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### design/sdfg_pkg.sv
// ----------------------------------------------------------------------------
// sdfg_pkg
// Shared types and constants of the stacked dots frame generator.
// ----------------------------------------------------------------------------
`default_nettype none

package sdfg_pkg;

  localparam int unsigned COLOR_W   = 40;
  localparam int unsigned CH_W      = 8;
  localparam int unsigned PC_W      = 7;
  localparam int unsigned PS_W      = 3;
  localparam int unsigned EXIT_W    = 2;
  localparam int unsigned SLOT_W    = 2;
  localparam int unsigned IDX_W     = 6;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned NUM_SLOTS = 4;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PIXEL_COUNT  = 3'd0,
    REG_PALETTE_SIZE = 3'd1,
    REG_FILL_A       = 3'd2,
    REG_FILL_B       = 3'd3,
    REG_FILL_C       = 3'd4,
    REG_FILL_D       = 3'd5,
    REG_EMPTY_COLOR  = 3'd6,
    REG_EXIT_MODE    = 3'd7
  } reg_idx_e;

  typedef enum logic [EXIT_W-1:0] {
    EXIT_NONE  = 2'd0,
    EXIT_LEFT  = 2'd1,
    EXIT_RIGHT = 2'd2
  } exit_mode_e;

  typedef enum logic [2:0] {
    PH_STACK = 3'b001,
    PH_LEFT  = 3'b010,
    PH_RIGHT = 3'b100
  } phase_e;

  typedef struct packed {
    logic frame_tick;
  } tick_t;

  typedef struct packed {
    logic [IDX_W-1:0] pixel_index;
    logic [CH_W-1:0]  red;
    logic [CH_W-1:0]  green;
    logic [CH_W-1:0]  blue;
    logic [CH_W-1:0]  white;
    logic [CH_W-1:0]  amber;
    logic             last_pixel;
  } pixel_t;

  // front end view of the configuration; pixel_count carries the new
  // count in the cycle that restart is raised
  typedef struct packed {
    logic [PC_W-1:0]   pixel_count;
    logic [PS_W-1:0]   palette_size;
    logic [EXIT_W-1:0] exit_mode;
    logic              restart;
  } front_cfg_t;

  typedef struct packed {
    logic [NUM_SLOTS-1:0][COLOR_W-1:0] fill;
    logic [COLOR_W-1:0]                empty;
  } colors_t;

endpackage

`default_nettype wire

### design/sdfg_stream_if.sv
// ----------------------------------------------------------------------------
// sdfg_stream_if
// Valid/ready channel carrying one payload item per handshake.
// ----------------------------------------------------------------------------
`default_nettype none

interface sdfg_stream_if #(
  parameter type payload_t = logic
) ();

  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);

endinterface

`default_nettype wire

### design/sdfg_front.sv
// ----------------------------------------------------------------------------
// sdfg_front
// Takes ticks, snapshots the animation state into a frame descriptor and
// steps the animation on.
// ----------------------------------------------------------------------------
`default_nettype none

module sdfg_front #(
  parameter int unsigned MAX_PIXELS    = 64,
  parameter int unsigned PALETTE_DEPTH = 4,
  parameter type         frame_t       = logic
) (
  input  wire                   clk_i,
  input  wire                   rst_ni,
  input  sdfg_pkg::front_cfg_t  cfg_i,
  sdfg_stream_if.sink           tick_i,
  sdfg_stream_if.source         frame_o
);

  localparam int unsigned CW = $clog2(MAX_PIXELS + 1);

  function automatic logic [CW-1:0] strip_len(input logic [sdfg_pkg::PC_W-1:0] pc);
    if (pc == '0) begin
      return CW'(1);
    end else if (32'(pc) > MAX_PIXELS) begin
      return CW'(MAX_PIXELS);
    end else begin
      return CW'(pc);
    end
  endfunction

  function automatic logic [sdfg_pkg::PS_W-1:0] palette_len(
    input logic [sdfg_pkg::PS_W-1:0] ps
  );
    if (ps == '0) begin
      return sdfg_pkg::PS_W'(1);
    end else if (32'(ps) > PALETTE_DEPTH) begin
      return sdfg_pkg::PS_W'(PALETTE_DEPTH);
    end else begin
      return ps;
    end
  endfunction

  sdfg_pkg::phase_e                phase_q, phase_d;
  logic [CW-1:0]                   stack_q, stack_d;
  logic [CW-1:0]                   mover_q, mover_d;
  logic [sdfg_pkg::SLOT_W-1:0]     slot_q, slot_d;

  logic [CW-1:0]                   n;
  logic [sdfg_pkg::PS_W-1:0]       plen;
  logic [sdfg_pkg::PS_W-1:0]       slot_inc;
  logic                            adv;

  assign n        = strip_len(cfg_i.pixel_count);
  assign plen     = palette_len(cfg_i.palette_size);
  assign slot_inc = sdfg_pkg::PS_W'(slot_q) + sdfg_pkg::PS_W'(1);

  // a tick of zero is consumed without a frame
  assign tick_i.ready  = frame_o.ready;
  assign frame_o.valid = tick_i.valid && tick_i.data.frame_tick;
  assign adv           = tick_i.valid && frame_o.ready && tick_i.data.frame_tick;

  always_comb begin
    frame_o.data       = '0;
    frame_o.data.left  = (phase_q == sdfg_pkg::PH_LEFT);
    frame_o.data.slot  = slot_q;
    frame_o.data.stack = stack_q;
    frame_o.data.mover = mover_q;
    frame_o.data.count = n;
  end

  always_comb begin
    phase_d = phase_q;
    stack_d = stack_q;
    mover_d = mover_q;
    slot_d  = slot_q;
    if (cfg_i.restart) begin
      phase_d = sdfg_pkg::PH_STACK;
      stack_d = n - CW'(1);
      mover_d = '0;
      slot_d  = '0;
    end else if (adv) begin
      unique case (phase_q)
        sdfg_pkg::PH_LEFT: begin
          if (mover_q < n - CW'(1)) begin
            mover_d = mover_q + CW'(1);
          end else if (stack_q != '0) begin
            stack_d = stack_q - CW'(1);
            mover_d = stack_q - CW'(1);
          end else begin
            slot_d  = (slot_inc >= plen) ? '0 : slot_inc[sdfg_pkg::SLOT_W-1:0];
            phase_d = sdfg_pkg::PH_STACK;
            stack_d = n - CW'(1);
            mover_d = '0;
          end
        end
        sdfg_pkg::PH_RIGHT: begin
          if (mover_q != '0) begin
            mover_d = mover_q - CW'(1);
          end else if (stack_q < n) begin
            stack_d = stack_q + CW'(1);
            mover_d = stack_q;
          end else begin
            slot_d  = (slot_inc >= plen) ? '0 : slot_inc[sdfg_pkg::SLOT_W-1:0];
            phase_d = sdfg_pkg::PH_STACK;
            stack_d = n - CW'(1);
            mover_d = '0;
          end
        end
        sdfg_pkg::PH_STACK: begin
          if (mover_q < stack_q) begin
            mover_d = mover_q + CW'(1);
          end else if (stack_q != '0) begin
            stack_d = stack_q - CW'(1);
            mover_d = '0;
          end else if (cfg_i.exit_mode == sdfg_pkg::EXIT_LEFT) begin
            phase_d = sdfg_pkg::PH_LEFT;
            stack_d = n - CW'(1);
            mover_d = n - CW'(1);
          end else if (cfg_i.exit_mode == sdfg_pkg::EXIT_RIGHT) begin
            phase_d = sdfg_pkg::PH_RIGHT;
            stack_d = CW'(1);
            mover_d = '0;
          end else begin
            // no exit, or the unused mode code
            slot_d  = (slot_inc >= plen) ? '0 : slot_inc[sdfg_pkg::SLOT_W-1:0];
            stack_d = n - CW'(1);
            mover_d = '0;
          end
        end
        default: begin
          phase_d = sdfg_pkg::PH_STACK;
          stack_d = n - CW'(1);
          mover_d = '0;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= sdfg_pkg::PH_STACK;
      stack_q <= strip_len(sdfg_pkg::PC_W'(8)) - CW'(1);
      mover_q <= '0;
      slot_q  <= '0;
    end else begin
      phase_q <= phase_d;
      stack_q <= stack_d;
      mover_q <= mover_d;
      slot_q  <= slot_d;
    end
  end

endmodule

`default_nettype wire

### design/sdfg_queue.sv
// ----------------------------------------------------------------------------
// sdfg_queue
// Two-entry descriptor queue between front and back end.
// ----------------------------------------------------------------------------
`default_nettype none

module sdfg_queue #(
  parameter type payload_t = logic
) (
  input  wire            clk_i,
  input  wire            rst_ni,
  sdfg_stream_if.sink    in_i,
  sdfg_stream_if.source  out_o
);

  localparam int unsigned DEPTH = 2;

  payload_t                     mem_q [DEPTH];
  logic                         wr_ptr_q, rd_ptr_q;
  logic [$clog2(DEPTH+1)-1:0]   count_q, count_d;
  logic                         push, pop;

  assign in_i.ready  = (count_q != DEPTH[$clog2(DEPTH+1)-1:0]);
  assign out_o.valid = (count_q != '0);
  assign out_o.data  = mem_q[rd_ptr_q];

  assign push = in_i.valid && in_i.ready;
  assign pop  = out_o.valid && out_o.ready;

  always_comb begin
    count_d = count_q;
    if (push && !pop) begin
      count_d = count_q + 1'b1;
    end else if (pop && !push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= '0;
    end else begin
      count_q <= count_d;
      if (push) begin
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (pop) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= in_i.data;
    end
  end

endmodule

`default_nettype wire

### design/sdfg_back.sv
// ----------------------------------------------------------------------------
// sdfg_back
// Walks a frame descriptor pixel by pixel into a registered output.
// ----------------------------------------------------------------------------
`default_nettype none

module sdfg_back #(
  parameter int unsigned CW      = 7,
  parameter type         frame_t = logic
) (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  sdfg_pkg::colors_t   colors_i,
  sdfg_stream_if.sink         frame_i,
  sdfg_stream_if.source       pixel_o
);

  logic                      busy_q;
  frame_t                    desc_q;
  logic [CW-1:0]             p_q;
  logic                      out_valid_q;
  sdfg_pkg::pixel_t          out_q, out_d;

  logic                      load, last, take, lit;
  logic [sdfg_pkg::COLOR_W-1:0] color;

  assign load = busy_q && (!out_valid_q || pixel_o.ready);
  assign last = (p_q == desc_q.count - CW'(1));
  assign take = frame_i.valid && frame_i.ready;

  assign frame_i.ready = !busy_q || (load && last);

  assign pixel_o.valid = out_valid_q;
  assign pixel_o.data  = out_q;

  always_comb begin
    if (desc_q.left) begin
      lit = (p_q < desc_q.stack) || (p_q == desc_q.mover);
    end else begin
      lit = (p_q > desc_q.stack) || (p_q == desc_q.mover);
    end
    color = lit ? colors_i.fill[desc_q.slot] : colors_i.empty;

    out_d.pixel_index = sdfg_pkg::IDX_W'(32'(p_q));
    out_d.red         = color[39:32];
    out_d.green       = color[31:24];
    out_d.blue        = color[23:16];
    out_d.white       = color[15:8];
    out_d.amber       = color[7:0];
    out_d.last_pixel  = last;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (take) begin
        busy_q <= 1'b1;
      end else if (load && last) begin
        busy_q <= 1'b0;
      end
      if (load) begin
        out_valid_q <= 1'b1;
      end else if (pixel_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      desc_q <= frame_i.data;
      p_q    <= '0;
    end else if (load) begin
      p_q <= p_q + CW'(1);
    end
    if (load) begin
      out_q <= out_d;
    end
  end

endmodule

`default_nettype wire

### design/stacked_dots_frame_generator_core.sv
// The first pixel of a tick passes the descriptor queue, the back end descriptor register
// and the registered pixel output before it is valid.
// The back end pixel walker gives one pixel per cycle while pixel_o is ready;
// consecutive frames follow without a gap.
// A tick of zero is consumed and yields nothing.
// Reset (async, active low) loads the register defaults and restarts the animation;
// writing pixel_count restarts it as well.
// ----------------------------------------------------------------------------
// stacked_dots_frame_generator_core
// Top level: configuration registers, front end, descriptor queue, back end.
// ----------------------------------------------------------------------------
`default_nettype none
`include "stacked_dots_frame_generator_core_macros.svh"

module stacked_dots_frame_generator_core #(
  parameter int unsigned MAX_PIXELS    = 64,
  parameter int unsigned PALETTE_DEPTH = 4
) (
  input  wire                                  clk_i,
  input  wire                                  rst_ni,
  input  wire                                  cfg_we_i,
  input  wire  [sdfg_pkg::CFG_IDX_W-1:0]       cfg_idx_i,
  input  wire  [sdfg_pkg::COLOR_W-1:0]         cfg_wdata_i,
  sdfg_stream_if.sink                          tick_i,
  sdfg_stream_if.source                        pixel_o
);

  localparam int unsigned CW = $clog2(MAX_PIXELS + 1);

  typedef struct packed {
    logic                        left;
    logic [sdfg_pkg::SLOT_W-1:0] slot;
    logic [CW-1:0]               stack;
    logic [CW-1:0]               mover;
    logic [CW-1:0]               count;
  } frame_t;

  logic [sdfg_pkg::PC_W-1:0]    pixel_count_q;
  logic [sdfg_pkg::PS_W-1:0]    palette_size_q;
  logic [sdfg_pkg::COLOR_W-1:0] fill_a_q, fill_b_q, fill_c_q, fill_d_q;
  logic [sdfg_pkg::COLOR_W-1:0] empty_q;
  logic [sdfg_pkg::EXIT_W-1:0]  exit_mode_q;

  sdfg_pkg::front_cfg_t         front_cfg;
  sdfg_pkg::colors_t            colors;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pixel_count_q  <= sdfg_pkg::PC_W'(8);
      palette_size_q <= sdfg_pkg::PS_W'(1);
      fill_a_q       <= 40'hFF_0000_0000;
      fill_b_q       <= '0;
      fill_c_q       <= '0;
      fill_d_q       <= '0;
      empty_q        <= '0;
      exit_mode_q    <= sdfg_pkg::EXIT_NONE;
    end else if (cfg_we_i) begin
      unique case (sdfg_pkg::reg_idx_e'(cfg_idx_i))
        sdfg_pkg::REG_PIXEL_COUNT:  pixel_count_q  <= cfg_wdata_i[sdfg_pkg::PC_W-1:0];
        sdfg_pkg::REG_PALETTE_SIZE: palette_size_q <= cfg_wdata_i[sdfg_pkg::PS_W-1:0];
        sdfg_pkg::REG_FILL_A:       fill_a_q       <= cfg_wdata_i;
        sdfg_pkg::REG_FILL_B:       fill_b_q       <= cfg_wdata_i;
        sdfg_pkg::REG_FILL_C:       fill_c_q       <= cfg_wdata_i;
        sdfg_pkg::REG_FILL_D:       fill_d_q       <= cfg_wdata_i;
        sdfg_pkg::REG_EMPTY_COLOR:  empty_q        <= cfg_wdata_i;
        sdfg_pkg::REG_EXIT_MODE:    exit_mode_q    <= cfg_wdata_i[sdfg_pkg::EXIT_W-1:0];
        default: ;
      endcase
    end
  end

  // restart takes the count being written, not the stale register
  always_comb begin
    front_cfg.restart      = cfg_we_i && (cfg_idx_i == sdfg_pkg::REG_PIXEL_COUNT);
    front_cfg.pixel_count  = front_cfg.restart ? cfg_wdata_i[sdfg_pkg::PC_W-1:0]
                                               : pixel_count_q;
    front_cfg.palette_size = palette_size_q;
    front_cfg.exit_mode    = exit_mode_q;
  end

  always_comb begin
    colors.fill[0] = fill_a_q;
    colors.fill[1] = fill_b_q;
    colors.fill[2] = fill_c_q;
    colors.fill[3] = fill_d_q;
    colors.empty   = empty_q;
  end

  sdfg_stream_if #(.payload_t(frame_t)) push_ch ();
  sdfg_stream_if #(.payload_t(frame_t)) pop_ch ();

  sdfg_front #(
    .MAX_PIXELS   (MAX_PIXELS),
    .PALETTE_DEPTH(PALETTE_DEPTH),
    .frame_t      (frame_t)
  ) u_front (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (front_cfg),
    .tick_i (tick_i),
    .frame_o(push_ch)
  );

  sdfg_queue #(
    .payload_t(frame_t)
  ) u_queue (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (push_ch),
    .out_o (pop_ch)
  );

  sdfg_back #(
    .CW     (CW),
    .frame_t(frame_t)
  ) u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .colors_i(colors),
    .frame_i (pop_ch),
    .pixel_o (pixel_o)
  );

  // a real tick always lands in the queue in the cycle it is taken
  `SDFG_ASSERT_NOW(a_tick_pushed, clk_i, rst_ni, tick_i.valid && tick_i.ready && tick_i.data.frame_tick, push_ch.valid && push_ch.ready, "accepted tick did not enqueue a frame")

  // after the last pixel a new frame starts at index zero
  `SDFG_ASSERT_NEXT(a_frame_restart, clk_i, rst_ni, pixel_o.valid && pixel_o.ready && pixel_o.data.last_pixel, !pixel_o.valid || (pixel_o.data.pixel_index == '0), "frame did not start at pixel zero")

  // within a frame pixels come in increasing order
  `SDFG_ASSERT_NEXT(a_pixel_order, clk_i, rst_ni, pixel_o.valid && pixel_o.ready && !pixel_o.data.last_pixel, !pixel_o.valid || (pixel_o.data.pixel_index == $past(pixel_o.data.pixel_index) + 6'd1), "pixel index skipped within frame")

endmodule

`default_nettype wire
